// ===== hw/rtl/dpl_pkg.sv =====
// Package: shared types and constants for the dash pattern lookup unit.
package dpl_pkg;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam int LEN_W   = 24;
	localparam int DIST_W  = 32;
	localparam int INDEX_W = 36;

	localparam logic [LEN_W-1:0]   LEN_MAX   = '1;
	localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
	localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

	// controller -> datapath commands
	typedef struct packed {
		logic load;       // capture input transaction
		logic add_exec;   // perform table add
		logic div_init;   // start modulo
		logic div_step;   // one quotient bit
		logic srch_init;  // start search
		logic srch_step;  // one search step
		logic fin_query;  // compute query result
		logic fin_other;  // compute clear/add/unused result
		logic out_take;   // output register consumed
	} dpl_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic div_done;
		logic srch_done;
		logic zero_len;   // pattern length is zero
		logic empty;
		logic is_query;
		logic out_full;
	} dpl_sts_t;

endpackage

// ===== hw/rtl/dash_pattern_lookup_unit.sv =====
// Top level: dash pattern table with modulo-and-search distance lookup.
// Sequence from acceptance to out_valid: clear/add and an empty-table query finish in dispatch;
//   other queries run dispatch, the modulo steps, a handoff, the search steps and the result
//   write; a zero-length pattern skips the modulo. Dispatch waits for a free output.
// Throughput: one transaction at a time; a new one is captured only once the controller is idle.
// Reset: arst_n clears the entry count, the controller and the output valid.
module dash_pattern_lookup_unit #(
	parameter int MAX_DASHES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// input channel
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   command,
	input  logic [23:0]  draw_length,
	input  logic [23:0]  skip_length,
	input  logic [31:0]  distance,
	// output channel
	output logic         out_valid,
	input  logic         out_stall,
	output logic         inside_draw,
	output logic [35:0]  dash_index,
	output logic         status
);
	import dpl_pkg::*;

	dpl_cmd_t cmd;
	dpl_sts_t sts;

	// Controller: one transaction in flight; result held until the
	// downstream side takes it, the next transaction can be captured
	// meanwhile.
	dpl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: table storage, modulo by pattern length, binary search.
	dpl_datapath #(
		.MAX_DASHES (MAX_DASHES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.command     (command),
		.draw_length (draw_length),
		.skip_length (skip_length),
		.distance    (distance),
		.inside_draw (inside_draw),
		.dash_index  (dash_index),
		.status      (status)
	);

endmodule

// ===== hw/rtl/dpl_datapath.sv =====
// Datapath: dash table, shift-subtract modulo, binary search and output register.
module dpl_datapath #(
	parameter int MAX_DASHES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dpl_pkg::dpl_cmd_t         cmd,
	output dpl_pkg::dpl_sts_t         sts,
	input  logic [1:0]                command,
	input  logic [dpl_pkg::LEN_W-1:0] draw_length,
	input  logic [dpl_pkg::LEN_W-1:0] skip_length,
	input  logic [dpl_pkg::DIST_W-1:0] distance,
	output logic                      inside_draw,
	output logic [dpl_pkg::INDEX_W-1:0] dash_index,
	output logic                      status
);
	import dpl_pkg::*;

	localparam int IDX_W = (MAX_DASHES > 1) ? $clog2(MAX_DASHES) : 1;
	localparam int CNT_W = $clog2(MAX_DASHES + 1);
	localparam int QC_W  = 6;

	logic [DIST_W-1:0] start_mem [MAX_DASHES];
	logic [LEN_W-1:0]  draw_mem  [MAX_DASHES];
	logic [LEN_W-1:0]  skip_mem  [MAX_DASHES];
	logic [DIST_W-1:0] end_mem   [MAX_DASHES];

	logic [CNT_W-1:0]  count_q;
	logic [DIST_W-1:0] plen_q;      // end of last entry
	logic [LEN_W-1:0]  last_skip_q;
	logic [LEN_W-1:0]  last_draw_q;

	logic [1:0]        cmd_q;
	logic [LEN_W-1:0]  draw_q, skip_q;
	logic [DIST_W-1:0] quo_q;        // dividend shifts out, quotient shifts in
	logic [DIST_W:0]   rem_q;
	logic [QC_W-1:0]   bit_q;
	logic [CNT_W-1:0]  lo_q, hi_q;
	logic              out_full_q;

	// read port, combinational address select through mid from the registered bounds
	logic [CNT_W-1:0]  mid;
	logic [IDX_W-1:0]  rd_addr;
	logic [DIST_W-1:0] rd_end;
	logic [IDX_W-1:0]  last_idx;
	logic [IDX_W-1:0]  new_idx;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign rd_addr = mid[IDX_W-1:0];
	assign rd_end  = end_mem[rd_addr];
	assign last_idx = IDX_W'(count_q - CNT_W'(1));
	assign new_idx  = count_q[IDX_W-1:0];

	logic merge;
	assign merge = (count_q != '0) && (last_skip_q == '0);

	logic [DIST_W:0]   sum_end;
	logic [LEN_W:0]    sum_draw, sum_skip;
	logic [LEN_W:0]    step;
	logic [DIST_W-1:0] sat_end;
	assign step     = {1'b0, draw_q} + {1'b0, skip_q};
	assign sum_end  = {1'b0, plen_q} + {{(DIST_W-LEN_W){1'b0}}, step};
	assign sat_end  = sum_end[DIST_W] ? DIST_MAX : sum_end[DIST_W-1:0];
	assign sum_draw = {1'b0, last_draw_q} + {1'b0, draw_q};
	assign sum_skip = {1'b0, last_skip_q} + {1'b0, skip_q};

	// table writes
	always_ff @(posedge clk) begin
		if (cmd.add_exec && cmd_q == CMD_ADD) begin
			if (merge) begin
				draw_mem[last_idx] <= sum_draw[LEN_W] ? LEN_MAX : sum_draw[LEN_W-1:0];
				skip_mem[last_idx] <= sum_skip[LEN_W] ? LEN_MAX : sum_skip[LEN_W-1:0];
				end_mem[last_idx]  <= sat_end;
			end else if (count_q < CNT_W'(MAX_DASHES)) begin
				start_mem[new_idx] <= plen_q;
				draw_mem[new_idx]  <= draw_q;
				skip_mem[new_idx]  <= skip_q;
				end_mem[new_idx]   <= sat_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			plen_q      <= '0;
			last_skip_q <= '0;
			last_draw_q <= '0;
		end else if (cmd.add_exec) begin
			if (cmd_q == CMD_CLEAR) begin
				count_q <= '0;
				plen_q  <= '0;
			end else if (cmd_q == CMD_ADD) begin
				if (merge) begin
					last_draw_q <= sum_draw[LEN_W] ? LEN_MAX : sum_draw[LEN_W-1:0];
					last_skip_q <= sum_skip[LEN_W] ? LEN_MAX : sum_skip[LEN_W-1:0];
					plen_q      <= sat_end;
				end else if (count_q < CNT_W'(MAX_DASHES)) begin
					last_draw_q <= draw_q;
					last_skip_q <= skip_q;
					plen_q      <= sat_end;
					count_q     <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// capture, modulo and search
	logic [DIST_W:0] rem_sh;
	logic [DIST_W:0] rem_sub;
	assign rem_sh  = {rem_q[DIST_W-1:0], quo_q[DIST_W-1]};
	assign rem_sub = rem_sh - {1'b0, plen_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= command;
			draw_q <= draw_length;
			skip_q <= skip_length;
			quo_q  <= distance;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			bit_q <= '0;
		end else if (cmd.div_step) begin
			if (!rem_sub[DIST_W]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[DIST_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIST_W-2:0], 1'b0};
			end
			bit_q <= bit_q + QC_W'(1);
		end
		if (cmd.srch_init) begin
			lo_q <= '0;
			hi_q <= count_q;
			// zero-length pattern: search raw distance, cycle 0
			if (plen_q == '0)
				rem_q <= {1'b0, quo_q};
		end else if (cmd.srch_step && lo_q < hi_q) begin
			if (rd_end < rem_q[DIST_W-1:0])
				lo_q <= mid + CNT_W'(1);
			else
				hi_q <= mid;
		end
	end

	// result
	logic [DIST_W-1:0]      cyc;
	logic [DIST_W+CNT_W-1:0] prod;
	logic [DIST_W+CNT_W:0]   idx_sum;
	logic [DIST_W:0]         in_sum;
	logic [IDX_W-1:0]        pos;
	assign cyc     = (plen_q == '0) ? '0 : quo_q;
	assign prod    = cyc * count_q;
	assign idx_sum = {1'b0, prod} + (DIST_W+CNT_W+1)'(lo_q);
	assign pos     = lo_q[IDX_W-1:0];
	assign in_sum  = {1'b0, start_mem[pos]} + (DIST_W+1)'(draw_mem[pos]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.fin_query || cmd.fin_other) begin
			out_full_q <= 1'b1;
		end else if (cmd.out_take) begin
			out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_query) begin
			status <= 1'b0;
			if (count_q == '0) begin
				inside_draw <= 1'b1;
				dash_index  <= '0;
			end else begin
				inside_draw <= (plen_q == '0) || (lo_q >= count_q) ||
					(in_sum >= rem_q);
				if ((DIST_W+CNT_W+1) > INDEX_W &&
				    (idx_sum >> INDEX_W) != '0)
					dash_index <= INDEX_MAX;
				else
					dash_index <= INDEX_W'(idx_sum);
			end
		end else if (cmd.fin_other) begin
			inside_draw <= 1'b0;
			dash_index  <= '0;
			status      <= (cmd_q == CMD_ADD) && !merge &&
				(count_q >= CNT_W'(MAX_DASHES));
		end
	end

	// last modulo step; the controller steps every cycle while dividing
	assign sts.div_done  = (bit_q == QC_W'(DIST_W - 1));
	assign sts.srch_done = !(lo_q < hi_q);
	assign sts.zero_len  = (plen_q == '0);
	assign sts.empty     = (count_q == '0);
	assign sts.is_query  = (cmd_q == CMD_QUERY);
	assign sts.out_full  = out_full_q;

endmodule

// ===== hw/rtl/dpl_ctrl.sv =====
// Controller: sequences capture, modulo, search and result for each transaction.
module dpl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	output logic              out_valid,
	input  dpl_pkg::dpl_sts_t sts,
	output dpl_pkg::dpl_cmd_t cmd
);
	import dpl_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DISP = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SRCH = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       take;

	assign out_valid = sts.out_full;
	assign take      = sts.out_full && !out_stall;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		cmd.out_take = take;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				// the output register must be free before a result is written
				if (!sts.out_full || take) begin
					if (!sts.is_query) begin
						cmd.add_exec  = 1'b1;
						cmd.fin_other = 1'b1;
						state_d       = ST_IDLE;
					end else if (sts.empty) begin
						cmd.fin_query = 1'b1;
						state_d       = ST_IDLE;
					end else if (sts.zero_len) begin
						cmd.srch_init = 1'b1;
						state_d       = ST_SRCH;
					end else begin
						cmd.div_init = 1'b1;
						state_d      = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.srch_init = 1'b1;
				state_d       = ST_SRCH;
			end
			ST_SRCH: begin
				if (sts.srch_done) begin
					cmd.fin_query = 1'b1;
					state_d       = ST_IDLE;
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sim/tb.sv =====
// Testbench for the dash pattern lookup unit: directed table plus random commands.
`timescale 1ns / 100ps

module tb;
	import dpl_pkg::*;

	localparam int DASHES = 16;
	localparam int RANDOM_TRANSACTIONS = 700;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = CMD_CLEAR;
	logic [23:0] draw_length = '0;
	logic [23:0] skip_length = '0;
	logic [31:0] distance = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic inside_draw;
	logic [35:0] dash_index;
	logic status;

	always #4 clk = ~clk;

	dash_pattern_lookup_unit #(.MAX_DASHES(DASHES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .draw_length(draw_length),
		.skip_length(skip_length), .distance(distance),
		.out_valid(out_valid), .out_stall(out_stall),
		.inside_draw(inside_draw), .dash_index(dash_index), .status(status)
	);

	typedef struct packed {
		logic in_draw;
		logic [35:0] index;
		logic full;
	} lookup_t;

	// Predicted dash table, mirrors what the block should hold.
	logic [31:0] tbl_start [DASHES];
	logic [23:0] tbl_draw [DASHES];
	logic [23:0] tbl_skip [DASHES];
	logic [31:0] tbl_end [DASHES];
	int unsigned tbl_count;

	lookup_t pending_lookups[$];
	int errors = 0;
	bit quiet = 1'b0;	// no idling near the end of the run

	function automatic logic [23:0] clip24(logic [63:0] v);
		return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
	endfunction

	function automatic logic [31:0] clip32(logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// First entry whose end is not below r; tbl_count if none.
	function automatic int unsigned find_entry(logic [31:0] r);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_end[mid] < r) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	// Apply one command to the predicted table and return its result.
	function automatic lookup_t predict_lookup(logic [1:0] cmd, logic [23:0] dl,
			logic [23:0] sl, logic [31:0] qdist);
		lookup_t res;
		logic [31:0] plen, rem, base;
		logic [63:0] cyc, idx;
		int unsigned pos, k;
		res = '0;
		case (cmd)
			CMD_CLEAR: tbl_count = 0;
			CMD_ADD: begin
				if (tbl_count > 0 && tbl_skip[tbl_count-1] == 0) begin
					// zero skip on the last dash: merge into it
					k = tbl_count - 1;
					tbl_draw[k] = clip24(64'(tbl_draw[k]) + dl);
					tbl_skip[k] = clip24(64'(tbl_skip[k]) + sl);
					tbl_end[k] = clip32(64'(tbl_end[k]) + dl + sl);
				end else if (tbl_count >= DASHES) begin
					res.full = 1'b1;
				end else begin
					k = tbl_count;
					base = (k == 0) ? 32'd0 : tbl_end[k-1];
					tbl_start[k] = base;
					tbl_draw[k] = dl;
					tbl_skip[k] = sl;
					tbl_end[k] = clip32(64'(base) + dl + sl);
					tbl_count = k + 1;
				end
			end
			CMD_QUERY: begin
				if (tbl_count == 0) begin
					res.in_draw = 1'b1;
				end else begin
					plen = tbl_end[tbl_count-1];
					if (plen == 0) begin
						res.in_draw = 1'b1;
						res.index = 36'(find_entry(qdist));
					end else begin
						cyc = 64'(qdist / plen);
						rem = qdist % plen;
						pos = find_entry(rem);
						if (pos >= tbl_count) res.in_draw = 1'b1;
						else res.in_draw = (64'(tbl_start[pos]) + tbl_draw[pos] >= rem);
						idx = 64'(pos) + 64'(tbl_count) * cyc;
						res.index = (idx > 64'hF_FFFF_FFFF) ? 36'hF_FFFF_FFFF : idx[35:0];
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Present one transaction; predict when it is accepted. Valid stays up
	// after acceptance until the next idle gap or drain.
	task automatic send_command(logic [1:0] cmd, logic [23:0] dl, logic [23:0] sl,
			logic [31:0] qdist);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		draw_length <= dl;
		skip_length <= sl;
		distance <= qdist;
		do @(posedge clk); while (in_stall);
		pending_lookups = {pending_lookups, predict_lookup(cmd, dl, sl, qdist)};
	endtask

	// Drop valid and wait for every outstanding result.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_lookups.size() != 0);
	endtask

	// Receiver side: random stall bursts, compare each accepted transaction.
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_lookups.size() == 0) begin
					$display("%0t: unexpected result inside=%0b index=%0d status=%0b",
						$time, inside_draw, dash_index, status);
					errors++;
				end else begin
					lookup_t want;
					want = pending_lookups.pop_front();
					if (inside_draw !== want.in_draw) begin
						$display("%0t: inside_draw expected %0b actual %0b",
							$time, want.in_draw, inside_draw);
						errors++;
					end
					if (dash_index !== want.index) begin
						$display("%0t: dash_index expected %0d actual %0d",
							$time, want.index, dash_index);
						errors++;
					end
					if (status !== want.full) begin
						$display("%0t: status expected %0b actual %0b",
							$time, want.full, status);
						errors++;
					end
				end
			end
			if (burst > 0) begin
				burst--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				burst = $urandom_range(1, 6);
			end
			out_stall <= (burst > 0);
		end
	end

	// Directed rows: command, draw, skip, distance, check flag, hand-typed result.
	typedef struct {
		logic [1:0] cmd;
		logic [23:0] dl;
		logic [23:0] sl;
		logic [31:0] qdist;
		bit typed;
		lookup_t res;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 22;
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		// empty table query right after reset
		'{CMD_QUERY, 24'd0, 24'd0, 32'hFFFF_FFFF, 1, '{1'b1, 36'd0, 1'b0}},
		'{CMD_UNUSED, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1, '0},
		// zero-length pattern: two zero dashes merge into one entry
		'{CMD_ADD, 24'd0, 24'd0, 32'd0, 1, '0},
		'{CMD_ADD, 24'd0, 24'd0, 32'd0, 1, '0},
		'{CMD_QUERY, 24'd0, 24'd0, 32'd0, 1, '{1'b1, 36'd0, 1'b0}},
		'{CMD_QUERY, 24'd0, 24'd0, 32'd5, 1, '{1'b1, 36'd1, 1'b0}},
		'{CMD_CLEAR, 24'd0, 24'd0, 32'd0, 1, '0},
		// ordinary pattern
		'{CMD_ADD, 24'h000100, 24'h000200, 32'd0, 1, '0},
		'{CMD_ADD, 24'h000080, 24'h000080, 32'd0, 1, '0},
		'{CMD_QUERY, 24'd0, 24'd0, 32'd0, 0, '0},
		'{CMD_QUERY, 24'd0, 24'd0, 32'h0000_0100, 0, '0},
		'{CMD_QUERY, 24'd0, 24'd0, 32'h0000_0101, 0, '0},
		'{CMD_QUERY, 24'd0, 24'd0, 32'h0000_0400, 0, '0},
		'{CMD_QUERY, 24'd0, 24'd0, 32'hFFFF_FFFF, 0, '0},
		// saturating lengths through a merge
		'{CMD_CLEAR, 24'd0, 24'd0, 32'd0, 1, '0},
		'{CMD_ADD, 24'hFF_FFFF, 24'd0, 32'd0, 1, '0},
		'{CMD_ADD, 24'hFF_FFFF, 24'hFF_FFFF, 32'd0, 1, '0},
		'{CMD_ADD, 24'hFF_FFFF, 24'hFF_FFFF, 32'd0, 1, '0},
		'{CMD_QUERY, 24'd0, 24'd0, 32'hFFFF_FFFF, 0, '0},
		'{CMD_QUERY, 24'd0, 24'd0, 32'h00FF_FFFF, 0, '0},
		// tiny pattern gives the largest cycle count
		'{CMD_CLEAR, 24'd0, 24'd0, 32'd0, 1, '0},
		'{CMD_ADD, 24'd1, 24'd1, 32'd0, 1, '0}
	};

	// Random command with a bias toward adds and queries.
	task automatic send_random();
		int sel;
		logic [23:0] dl, sl;
		logic [31:0] qdist;
		sel = $urandom_range(0, 99);
		dl = (sel % 5 == 0) ? 24'($urandom) : 24'($urandom_range(0, 4096));
		sl = ($urandom_range(0, 5) == 0) ? 24'd0 :
			(sel % 7 == 0) ? 24'($urandom) : 24'($urandom_range(0, 4096));
		qdist = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 200000));
		if (sel < 4) send_command(CMD_CLEAR, dl, sl, qdist);
		else if (sel < 6) send_command(CMD_UNUSED, dl, sl, qdist);
		else if (sel < 45) send_command(CMD_ADD, dl, sl, qdist);
		else send_command(CMD_QUERY, dl, sl, qdist);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			lookup_t typed_res;
			send_command(directed_rows[i].cmd, directed_rows[i].dl, directed_rows[i].sl,
				directed_rows[i].qdist);
			// hand-typed result must agree with the prediction just queued
			typed_res = pending_lookups[$];
			if (directed_rows[i].typed && typed_res !== directed_rows[i].res) begin
				$display("%0t: row %0d expected %h predicted %h",
					$time, i, directed_rows[i].res, typed_res);
				errors++;
			end
		end
		send_command(CMD_QUERY, 24'd0, 24'd0, 32'hFFFF_FFFF);

		// fill the table to the brim, then overflow and merge when full
		send_command(CMD_CLEAR, 24'd0, 24'd0, 32'd0);
		for (int i = 0; i < DASHES; i++)
			send_command(CMD_ADD, 24'($urandom_range(1, 300)),
				(i == DASHES - 1) ? 24'd0 : 24'($urandom_range(1, 300)), 32'd0);
		send_command(CMD_ADD, 24'd7, 24'd9, 32'd0);	// merges into last entry
		send_command(CMD_ADD, 24'd5, 24'd5, 32'd0);	// rejected, full
		send_command(CMD_QUERY, 24'd0, 24'd0, $urandom);

		// sender holds off until everything is back
		drain_results();

		for (int n = 0; n < RANDOM_TRANSACTIONS; n++) begin
			if (n == RANDOM_TRANSACTIONS - 80) quiet = 1'b1;
			if ($urandom_range(0, 60) == 0) begin
				// well-formed pattern rebuilt from scratch
				send_command(CMD_CLEAR, 24'd0, 24'd0, 32'd0);
				repeat ($urandom_range(1, DASHES + 2))
					send_command(CMD_ADD, 24'($urandom_range(0, 2000)),
						24'($urandom_range(0, 2000)), 32'd0);
			end
			send_random();
		end

		drain_results();
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: FAIL");
		$finish;
	end
endmodule

// ===== dash_pattern_lookup_unit.f =====
hw/rtl/dpl_pkg.sv
hw/rtl/dpl_datapath.sv
hw/rtl/dpl_ctrl.sv
hw/rtl/dash_pattern_lookup_unit.sv
sim/tb.sv
